FILE: rtl/rsame_pkg.sv
// shared types and constants of the modular exponentiation block
// no dependencies
package rsame_pkg;

  localparam int KEY_WIDTH = 32;
  localparam int CNT_W     = $clog2(KEY_WIDTH);
  localparam int CFG_W     = 32;
  localparam int IDX_W     = 1;

  localparam logic [IDX_W-1:0] REG_MODULUS  = 1'b0;
  localparam logic [IDX_W-1:0] REG_EXPONENT = 1'b1;

  typedef enum logic {
    OP_MUL,
    OP_SQR
  } op_e;

  // one product in flight through the reduction chain
  typedef struct packed {
    logic                 vld;
    op_e                  op;
    logic [KEY_WIDTH-1:0] r;
    logic [KEY_WIDTH-1:0] a;
    logic [KEY_WIDTH-1:0] b;
  } cell_t;

endpackage

FILE: rtl/rsame_cell.sv
// one interleaved multiply and reduce step: r = (2r + a_msb*b) mod m
// depends on rsame_pkg
module rsame_cell
  import rsame_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [KEY_WIDTH-1:0] mod_i,
  input  cell_t                cell_i,
  output cell_t                cell_o
);

  logic [KEY_WIDTH+1:0] mod_ext;
  logic [KEY_WIDTH+1:0] sum;
  logic [KEY_WIDTH+1:0] red1;
  logic [KEY_WIDTH+1:0] red2;
  logic                 vld_q;
  op_e                  op_q;
  logic [KEY_WIDTH-1:0] r_q, a_q, b_q;

  // doubled remainder plus addend stays below three times the modulus
  always_comb begin
    mod_ext = {2'b00, mod_i};
    sum     = {1'b0, cell_i.r, 1'b0} + (cell_i.a[KEY_WIDTH-1] ? {2'b00, cell_i.b} : '0);
    red1    = (sum >= mod_ext) ? sum - mod_ext : sum;
    red2    = (red1 >= mod_ext) ? red1 - mod_ext : red1;
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= cell_i.vld;
    end
  end

  // payload handed to the next cell
  always_ff @(posedge clk_i) begin
    op_q <= cell_i.op;
    r_q  <= red2[KEY_WIDTH-1:0];
    a_q  <= {cell_i.a[KEY_WIDTH-2:0], 1'b0};
    b_q  <= cell_i.b;
  end

  assign cell_o = '{vld: vld_q, op: op_q, r: r_q, a: a_q, b: b_q};

endmodule

FILE: rtl/rsame_chain.sv
// row of reduction cells, one per multiplier bit
// depends on rsame_pkg and rsame_cell
module rsame_chain
  import rsame_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [KEY_WIDTH-1:0] mod_i,
  input  cell_t                cell_i,
  output cell_t                cell_o
);

  cell_t link [KEY_WIDTH+1];

  assign link[0] = cell_i;

  // each cell passes its partial remainder to its neighbor every cycle
  for (genvar k = 0; k < KEY_WIDTH; k++) begin : g_cell
    rsame_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .mod_i  (mod_i),
      .cell_i (link[k]),
      .cell_o (link[k+1])
    );
  end

  assign cell_o = link[KEY_WIDTH];

endmodule

FILE: rtl/rsa_modular_exponentiation.sv
// modular exponentiation top level: config registers, square-and-multiply sequencer
// depends on rsame_pkg and rsame_chain
//
// channel   dir  fields (low bit up)        handshake
// s_axis    in   tdata: base_value[31:0]     tvalid/tready
// m_axis    out  tdata: power_result[31:0]   tvalid/tready
// cfg       in   idx 0 modulus, 1 exponent   cfg_we_i, no wait
//
// an item takes one base reduction through the KEY_WIDTH-cell chain, then per
// exponent bit a multiply (only when that bit is set) and a square issued back
// to back that each cross the chain.
// exponent zero or modulus zero skip the chain.
// reset clears control state; results wait in an output register so the
// next item is taken while a finished one is still unclaimed.
module rsa_modular_exponentiation
  import rsame_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [31:0]      s_axis_tdata,   // base_value[31:0]
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [31:0]      m_axis_tdata    // power_result[31:0]
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED,
    ST_MUL,
    ST_SQR,
    ST_WAIT,
    ST_DONE
  } state_e;

  localparam logic [CNT_W-1:0]     LAST_BIT = CNT_W'(KEY_WIDTH - 1);
  localparam logic [KEY_WIDTH-1:0] ONE      = KEY_WIDTH'(1);

  state_e               state_q;
  logic [KEY_WIDTH-1:0] mod_q, exp_q;
  logic [KEY_WIDTH-1:0] acc_q, sq_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [1:0]           pend_q;
  logic                 out_vld_q;
  logic [KEY_WIDTH-1:0] out_q;
  cell_t                issue, ret;
  logic                 in_acc;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = 32'(out_q);

  // product issued into the chain
  always_comb begin
    issue = '{vld: 1'b0, op: OP_SQR, r: '0, a: sq_q, b: sq_q};
    case (state_q)
      ST_IDLE: begin
        issue.vld = in_acc && (exp_q != '0) && (mod_q != '0);
        issue.a   = s_axis_tdata[KEY_WIDTH-1:0];
        issue.b   = ONE;
      end
      ST_MUL: begin
        issue.vld = exp_q[cnt_q];
        issue.op  = OP_MUL;
        issue.a   = acc_q;
      end
      ST_SQR:  issue.vld = 1'b1;
      default: issue.vld = 1'b0;
    endcase
  end

  rsame_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mod_i  (mod_q),
    .cell_i (issue),
    .cell_o (ret)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= ONE;
      exp_q <= ONE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODULUS:  mod_q <= cfg_data_i[KEY_WIDTH-1:0];
        REG_EXPONENT: exp_q <= cfg_data_i[KEY_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      pend_q    <= '0;
      out_vld_q <= 1'b0;
      acc_q     <= '0;
      sq_q      <= '0;
      out_q     <= '0;
    end else begin
      pend_q <= pend_q + 2'(issue.vld) - 2'(ret.vld);
      if (m_axis_tready && (state_q != ST_DONE)) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (exp_q == '0) begin
              acc_q   <= ONE;
              state_q <= ST_DONE;
            end else if (mod_q == '0) begin
              acc_q   <= '0;
              state_q <= ST_DONE;
            end else begin
              acc_q   <= (mod_q == ONE) ? '0 : ONE;
              state_q <= ST_RED;
            end
          end
        end
        ST_RED: begin
          if (ret.vld) begin
            sq_q    <= ret.r;
            cnt_q   <= '0;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: state_q <= ST_SQR;
        ST_SQR: state_q <= ST_WAIT;
        ST_WAIT: begin
          if (ret.vld) begin
            if (ret.op == OP_MUL) begin
              acc_q <= ret.r;
            end else begin
              sq_q <= ret.r;
            end
          end
          if (pend_q == '0) begin
            if (cnt_q == LAST_BIT) begin
              state_q <= ST_DONE;
            end else begin
              cnt_q   <= cnt_q + 1'b1;
              state_q <= ST_MUL;
            end
          end
        end
        ST_DONE: begin
          if (!out_vld_q || m_axis_tready) begin
            out_vld_q <= 1'b1;
            out_q     <= acc_q;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // at most a multiply and a square in the chain at once
  assert property (@(posedge clk_i) disable iff (!rst_ni) pend_q <= 2'd2)
    else $error("too many products in flight");

  // nothing leaves the chain unless it was issued
  assert property (@(posedge clk_i) disable iff (!rst_ni) ret.vld |-> pend_q != '0)
    else $error("chain returned an unissued product");

  // the chain is empty whenever a new item may enter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (pend_q == '0))
    else $error("products left over between items");

  // a result is loaded only once the output register is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready) |=> out_vld_q && $stable(out_q))
    else $error("pending result overwritten");

endmodule
